// ----- design/fas_pkg.sv -----
// package for the single-precision add/subtract unit: types, opcodes, constants
`default_nettype none
package fas_pkg;
	localparam int unsigned MantLen = 23;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_NEG = 2'd2,
		OP_ABS = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
	} fas_in_t;

	typedef struct packed {
		logic [31:0] result_bits;
		logic        exponent_range_flag;
	} fas_out_t;
endpackage
`default_nettype wire

// ----- design/fas_core.sv -----
// combinational datapath: align, add, normalize, repack; negate and abs bypass the adder
`default_nettype none
module fas_core (
	input  wire fas_pkg::fas_in_t  req,
	output fas_pkg::fas_out_t      rsp
);
	logic [31:0] a, b;
	logic [7:0]  ea, eb, emax, diff;
	logic [23:0] ma, mb;
	logic [24:0] mas, mbs;
	logic [25:0] sa, sb, sum;
	logic [24:0] mag;
	logic [4:0]  top;
	logic [9:0]  ez;
	logic [24:0] norm;
	logic        sgn, swap;

	always_comb begin
		a = req.operand_a;
		b = (req.opcode == fas_pkg::OP_SUB) ? (req.operand_b ^ 32'h8000_0000)
			: req.operand_b;
		ea = a[30:23];
		eb = b[30:23];
		ma = {1'b1, a[22:0]};
		mb = {1'b1, b[22:0]};
		swap = ea < eb;
		emax = swap ? eb : ea;
		diff = swap ? (eb - ea) : (ea - eb);
		mas = {1'b0, ma};
		mbs = {1'b0, mb};
		if (swap) begin
			mas = (diff >= 8'd32) ? 25'd0 : ({1'b0, ma} >> diff[4:0]);
		end else begin
			mbs = (diff >= 8'd32) ? 25'd0 : ({1'b0, mb} >> diff[4:0]);
		end
		sa = a[31] ? -{1'b0, mas} : {1'b0, mas};
		sb = b[31] ? -{1'b0, mbs} : {1'b0, mbs};
		sum = sa + sb;
		sgn = sum[25];
		mag = sgn ? 25'(-sum) : sum[24:0];
		top = 5'd0;
		for (int i = 1; i < 25; i++) begin
			if (mag[i]) top = 5'(i);
		end
		// magnitude is at most 25 bits, so lead is in -23..1
		ez = {2'b00, emax} + 10'(top) - 10'(fas_pkg::MantLen);
		norm = (top >= 5'd23) ? (mag >> (top - 5'd23)) : (mag << (5'd23 - top));
		rsp.result_bits = {sgn, ez[7:0], norm[22:0]};
		rsp.exponent_range_flag = ez[9] || (ez == 10'd0) || (ez > 10'd254);
		if (sum == 26'd0) rsp = '0;
		case (req.opcode)
			fas_pkg::OP_NEG: rsp = '{result_bits: a ^ 32'h8000_0000,
				exponent_range_flag: 1'b0};
			fas_pkg::OP_ABS: rsp = '{result_bits: {1'b0, a[30:0]},
				exponent_range_flag: 1'b0};
			default: begin
				if (a == 32'd0) rsp = '{result_bits: b, exponent_range_flag: 1'b0};
				else if (b == 32'd0) rsp = '{result_bits: a, exponent_range_flag: 1'b0};
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- design/float32_add_sub_unit.sv -----
// top level of the single-precision add/subtract/negate/abs unit
`default_nettype none
// one operation per cycle: an operation started at one edge is captured in the
// input register, worked through one pass of combinational logic and captured in
// the result register, which shows it with done high; busy is always low, so
// start may be held high every cycle. the receiver cannot stall, and each result
// is shown for one cycle only.
module float32_add_sub_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire fas_pkg::fas_in_t  in_data,
	output logic                done,
	output fas_pkg::fas_out_t   out_data
);
	fas_pkg::fas_in_t  req_s1;
	logic              vld_s1;
	fas_pkg::fas_out_t rsp;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start;
	end
	always_ff @(posedge clk) begin
		if (start) req_s1 <= in_data;
	end

	fas_core u_core (.req(req_s1), .rsp(rsp));

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (vld_s1) out_data <= rsp;
	end

`ifndef ASSERT_OFF
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done) else $error("missing result transfer");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |=> !done) else $error("spurious result transfer");
	a_neg_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && req_s1.opcode[1]) |=> !out_data.exponent_range_flag)
		else $error("flag raised on negate or abs");
`endif
endmodule
`default_nettype wire
